// ===== rtl/core/nrobf_pkg.sv =====
// ----------------------------------------------------------------------------
// nrobf_pkg: shared types, constants and character functions
// Radix-64 alphabet, marker code and the result list passed between the
// string step logic and the top level.
// ----------------------------------------------------------------------------
package nrobf_pkg;

	localparam int          MAX_RES  = 7;
	localparam int          CNT_W    = 3;
	localparam logic [7:0]  MARKER   = 8'h7f;
	localparam logic [5:0]  OFF_STEP = 6'd11;
	localparam logic [5:0]  LO_BIAS  = 6'd5;
	localparam logic [1:0]  PAIR_MAX = 2'd3;
	localparam logic [1:0]  SEED_PAIRS = 2'd2;

	localparam logic        MODE_ENC = 1'b0;
	localparam logic        MODE_DEC = 1'b1;

	localparam logic        REG_SEED_LOW  = 1'b0;
	localparam logic        REG_SEED_HIGH = 1'b1;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_data;
		logic       eos;
		logic       bad;
	} res_t;

	typedef struct packed {
		logic [CNT_W-1:0]       count;
		res_t [MAX_RES-1:0]     ent;
	} step_res_t;

	// index 0..63 to "A-Z a-z 0-9 + /"
	function automatic logic [7:0] radix_char(input logic [5:0] idx);
		logic [7:0] c;
		if (idx < 6'd26) begin
			c = 8'h41 + {2'b00, idx};
		end else if (idx < 6'd52) begin
			c = 8'h61 + {2'b00, idx} - 8'd26;
		end else if (idx < 6'd62) begin
			c = 8'h30 + {2'b00, idx} - 8'd52;
		end else if (idx == 6'd62) begin
			c = 8'h2b;
		end else begin
			c = 8'h2f;
		end
		return c;
	endfunction

	// character to {ok, index}; index is zero when not in the alphabet
	function automatic logic [6:0] radix_pos(input logic [7:0] c);
		logic       ok;
		logic [5:0] idx;
		ok  = 1'b1;
		idx = 6'd0;
		if (c >= 8'h41 && c <= 8'h5a) begin
			idx = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			idx = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			idx = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2b) begin
			idx = 6'd62;
		end else if (c == 8'h2f) begin
			idx = 6'd63;
		end else begin
			ok = 1'b0;
		end
		return {ok, idx};
	endfunction

	function automatic logic [7:0] enc_char(input logic [3:0] nib, input logic [5:0] off,
			input logic [5:0] bias);
		return radix_char(6'({2'b00, nib}) + off + bias);
	endfunction

endpackage

// ===== rtl/core/nrobf_step.sv =====
// ----------------------------------------------------------------------------
// nrobf_step: per-string state and single-pass expansion of one request
// Holds the string state and seed store, and builds the full result list of
// one request combinationally; state advances when the request is taken.
// ----------------------------------------------------------------------------
module nrobf_step import nrobf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic       mode,
	input  logic [7:0] data,
	input  logic       last,
	input  logic [7:0] seed_low,
	input  logic [7:0] seed_high,
	output step_res_t  res
);

	logic       start_q, plain_q, phase_q, par_q, err_q;
	logic [5:0] off_q;
	logic [3:0] held_q;
	logic [1:0] pc_q;
	logic [7:0] seed_q [2];

	logic       start_n, plain_n, phase_n, par_n, err_n;
	logic [5:0] off_n, o_pay, p;
	logic [3:0] held_n, lo;
	logic [1:0] pc_n;
	logic [7:0] b, sel_seed, dbyte;
	logic [6:0] pos;
	logic       seed_we0, seed_we1, bad;
	logic [7:0] seed_d0, seed_d1;
	logic [CNT_W-1:0] n;

	assign pos = radix_pos(data);

	always_comb begin
		start_n  = start_q;
		plain_n  = plain_q;
		phase_n  = phase_q;
		par_n    = par_q;
		err_n    = err_q;
		off_n    = off_q;
		held_n   = held_q;
		pc_n     = pc_q;
		seed_we0 = 1'b0;
		seed_we1 = 1'b0;
		seed_d0  = seed_low;
		seed_d1  = seed_high;
		res      = '0;
		n        = '0;
		bad      = 1'b0;
		o_pay    = off_q;
		sel_seed = seed_q[par_q];
		b        = '0;
		p        = '0;
		lo       = '0;
		dbyte    = '0;
		if (mode == MODE_ENC) begin
			if (start_q) begin
				// latch the seed and lead with marker plus both seed bytes
				seed_we0 = 1'b1;
				seed_we1 = 1'b1;
				sel_seed = par_q ? seed_high : seed_low;
				o_pay    = off_q + OFF_STEP + OFF_STEP;
				res.ent[0] = '{out_byte: MARKER, has_data: 1'b1, eos: 1'b0, bad: 1'b0};
				res.ent[1] = '{enc_char(seed_low[7:4], off_q, 6'd0), 1'b1, 1'b0, 1'b0};
				res.ent[2] = '{enc_char(seed_low[3:0], off_q, LO_BIAS), 1'b1, 1'b0, 1'b0};
				res.ent[3] = '{enc_char(seed_high[7:4], off_q + OFF_STEP, 6'd0),
					1'b1, 1'b0, 1'b0};
				res.ent[4] = '{enc_char(seed_high[3:0], off_q + OFF_STEP, LO_BIAS),
					1'b1, 1'b0, 1'b0};
				start_n = 1'b0;
				plain_n = 1'b0;
			end
			b = data ^ sel_seed;
			if (start_q) begin
				res.ent[5] = '{enc_char(b[7:4], o_pay, 6'd0), 1'b1, 1'b0, 1'b0};
				res.ent[6] = '{enc_char(b[3:0], o_pay, LO_BIAS), 1'b1, 1'b0, 1'b0};
				n = CNT_W'(MAX_RES);
			end else begin
				res.ent[0] = '{enc_char(b[7:4], o_pay, 6'd0), 1'b1, 1'b0, 1'b0};
				res.ent[1] = '{enc_char(b[3:0], o_pay, LO_BIAS), 1'b1, 1'b0, 1'b0};
				n = CNT_W'(2);
			end
			off_n = o_pay + OFF_STEP;
			par_n = !par_q;
		end else if (start_q) begin
			start_n = 1'b0;
			if (data == MARKER) begin
				plain_n = 1'b0;
			end else begin
				plain_n    = 1'b1;
				res.ent[0] = '{data, 1'b1, 1'b0, 1'b0};
				n          = CNT_W'(1);
			end
		end else if (plain_q) begin
			res.ent[0] = '{data, 1'b1, 1'b0, 1'b0};
			n          = CNT_W'(1);
		end else begin
			if (!pos[6]) begin
				err_n = 1'b1;
			end
			p = pos[5:0];
			if (!phase_q) begin
				held_n  = 4'(p - off_q);
				phase_n = 1'b1;
			end else begin
				lo      = 4'(p - off_q - LO_BIAS);
				dbyte   = {held_q, lo};
				off_n   = off_q + OFF_STEP;
				phase_n = 1'b0;
				if (pc_q < SEED_PAIRS) begin
					seed_we0 = (pc_q[0] == 1'b0);
					seed_we1 = (pc_q[0] == 1'b1);
					seed_d0  = dbyte;
					seed_d1  = dbyte;
				end else begin
					res.ent[0] = '{dbyte ^ seed_q[par_q], 1'b1, 1'b0, 1'b0};
					n          = CNT_W'(1);
					par_n      = !par_q;
				end
				if (pc_q != PAIR_MAX) begin
					pc_n = pc_q + 2'd1;
				end
			end
		end
		if (last) begin
			bad = (mode == MODE_DEC) &&
				(err_n || (!plain_n && (pc_n < SEED_PAIRS || phase_n)));
			// status-only result when nothing else came out
			if (n == '0) begin
				n = CNT_W'(1);
			end
			for (int i = 0; i < MAX_RES; i++) begin
				if (CNT_W'(i) == n - CNT_W'(1)) begin
					res.ent[i].eos = 1'b1;
					res.ent[i].bad = bad;
				end
			end
			start_n = 1'b1;
			plain_n = 1'b0;
			phase_n = 1'b0;
			par_n   = 1'b0;
			err_n   = 1'b0;
			off_n   = '0;
			held_n  = '0;
			pc_n    = '0;
		end
		res.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			plain_q <= 1'b0;
			phase_q <= 1'b0;
			par_q   <= 1'b0;
			err_q   <= 1'b0;
			off_q   <= '0;
			held_q  <= '0;
			pc_q    <= '0;
		end else if (take) begin
			start_q <= start_n;
			plain_q <= plain_n;
			phase_q <= phase_n;
			par_q   <= par_n;
			err_q   <= err_n;
			off_q   <= off_n;
			held_q  <= held_n;
			pc_q    <= pc_n;
		end
	end

	// seed store: no reset, valid once written
	always_ff @(posedge clk) begin
		if (take && seed_we0) begin
			seed_q[0] <= seed_d0;
		end
		if (take && seed_we1) begin
			seed_q[1] <= seed_d1;
		end
	end

endmodule

// ===== rtl/core/nibble_radix64_obfuscation_codec.sv =====
// ----------------------------------------------------------------------------
// nibble_radix64_obfuscation_codec: streaming password obfuscation codec
// Encodes plaintext into marked radix-64 text and decodes it back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one string element per
//   request: mode (0 encode, 1 decode), data and last. Output channel
//   (out_valid / out_stall) carries out_byte, has_data, end_of_string and
//   bad_input; on bad_input the consumer drops the whole string.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) sets the two
//   seed bytes; cfg_ready is always high. Write only while the block is idle.
//   The first result of a request appears in the cycle after it is
//   taken. The results of one request leave one per cycle from a result
//   register while out_stall is low. A request gives 2 results per encoded
//   byte, 7 for the first byte of an encoded string, 1 per decoded
//   character (0 for marker, seed and first-nibble characters; a closing
//   request always has at least one). A new request is taken in the cycle
//   the last result of the previous one leaves, so the rate is set by the
//   output port alone.
//   Reset clears the string state and the seed registers and empties the
//   result register. A stalled receiver holds the current result; the input
//   side is then stalled until the held list drains.
// ----------------------------------------------------------------------------
module nibble_radix64_obfuscation_codec import nrobf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [7:0] data,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_data,
	output logic       end_of_string,
	output logic       bad_input,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0]       seed_low_q, seed_high_q;
	step_res_t        step_res;
	step_res_t        list_s1;
	logic             busy_q;
	logic [CNT_W-1:0] rd_q;
	logic             take, out_take, drain_done;
	res_t             cur;

	// configuration: always ready, one register per index
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_low_q  <= '0;
			seed_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEED_LOW:  seed_low_q  <= cfg_data;
				REG_SEED_HIGH: seed_high_q <= cfg_data;
				default:       seed_low_q  <= seed_low_q;
			endcase
		end
	end

	// expand one request into its full result list
	nrobf_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.mode      (mode),
		.data      (data),
		.last      (last),
		.seed_low  (seed_low_q),
		.seed_high (seed_high_q),
		.res       (step_res)
	);

	// the held list drains one entry per cycle while out_stall is low; take the next
	// request as the final entry leaves, so a waiting request is taken without a gap
	assign out_take   = busy_q && !out_stall;
	assign drain_done = out_take && (rd_q == list_s1.count - CNT_W'(1));
	assign in_stall   = busy_q && !drain_done;
	assign take       = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_q   <= '0;
		end else if (take) begin
			// a request with no results leaves the list empty
			busy_q <= (step_res.count != '0);
			rd_q   <= '0;
		end else if (drain_done) begin
			busy_q <= 1'b0;
			rd_q   <= '0;
		end else if (out_take) begin
			rd_q <= rd_q + CNT_W'(1);
		end
	end

	// result list payload: no reset
	always_ff @(posedge clk) begin
		if (take) begin
			list_s1 <= step_res;
		end
	end

	assign cur           = list_s1.ent[rd_q];
	assign out_valid     = busy_q;
	assign out_byte      = cur.out_byte;
	assign has_data      = cur.has_data;
	assign end_of_string = cur.eos;
	assign bad_input     = cur.bad;

	// the read pointer stays inside the held list
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rd_q < list_s1.count))
		else $error("read pointer beyond held result list");

	// a request with results shows its first result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && step_res.count != '0) |=> (out_valid && rd_q == '0))
		else $error("taken request did not present a result");

	// an error flag only rides on the closing result of a string
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_input) |-> end_of_string)
		else $error("bad_input without end_of_string");

	// with nothing held the input side is never stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !in_stall)
		else $error("input stalled while result list empty");

endmodule

// ===== verif/obf_stream_checker.sv =====
// ----------------------------------------------------------------------------
// obf_stream_checker: result predictor and scoreboard for the codec
// Follows the request, result and seed write channels, works out the
// characters each accepted request must produce and compares every accepted
// result, field by field, against the oldest one still owed.
// ----------------------------------------------------------------------------
module obf_stream_checker import nrobf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic       mode,
	input  logic [7:0] data,
	input  logic       last,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_byte,
	input  logic       has_data,
	input  logic       end_of_string,
	input  logic       bad_input,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output int         errors,
	output int         pending
);

	localparam logic [8*64-1:0] RADIX_SET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// seed registers as written, and the per-string codec state
	logic [7:0] seed_lo, seed_hi;
	logic [7:0] seed_mem [2];
	logic       at_start, plain_pass, nib_phase, parity, err_seen;
	logic [5:0] offset;
	logic [3:0] held;
	logic [1:0] pairs;
	res_t       owed_chars [$];
	int         err_count;

	function automatic logic [7:0] radix_of(input logic [5:0] idx);
		return RADIX_SET[8*(63-idx) +: 8];
	endfunction

	// position of a character in the alphabet; zero and not found otherwise
	task automatic find_radix(input logic [7:0] c, output logic found, output logic [5:0] pos);
		found = 1'b0;
		pos   = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (!found && radix_of(6'(i)) == c) begin
				found = 1'b1;
				pos   = 6'(i);
			end
		end
	endtask

	task automatic owe_char(input logic [7:0] c, input logic carries);
		res_t r;
		r.out_byte = c;
		r.has_data = carries;
		r.eos      = 1'b0;
		r.bad      = 1'b0;
		owed_chars.insert(owed_chars.size(), r);
	endtask

	task automatic owe_encoded(input logic [7:0] b);
		logic [5:0] hi_pos, lo_pos;
		hi_pos = {2'b00, b[7:4]} + offset;
		lo_pos = {2'b00, b[3:0]} + offset + LO_BIAS;
		owe_char(radix_of(hi_pos), 1'b1);
		owe_char(radix_of(lo_pos), 1'b1);
		offset = offset + OFF_STEP;
	endtask

	task automatic clear_string();
		at_start   = 1'b1;
		plain_pass = 1'b0;
		offset     = 6'd0;
		held       = 4'd0;
		nib_phase  = 1'b0;
		parity     = 1'b0;
		pairs      = 2'd0;
		err_seen   = 1'b0;
	endtask

	task automatic predict_request(input logic m, input logic [7:0] d, input logic l);
		int         base;
		logic       found, flag;
		logic [5:0] pos, diff;
		logic [7:0] whole;
		res_t       tail;
		base = owed_chars.size();
		if (m == MODE_ENC) begin
			if (at_start) begin
				seed_mem[0] = seed_lo;
				seed_mem[1] = seed_hi;
				owe_char(MARKER, 1'b1);
				owe_encoded(seed_lo);
				owe_encoded(seed_hi);
				at_start   = 1'b0;
				plain_pass = 1'b0;
			end
			owe_encoded(d ^ seed_mem[parity]);
			parity = ~parity;
		end else if (at_start) begin
			at_start = 1'b0;
			if (d == MARKER) begin
				plain_pass = 1'b0;
			end else begin
				plain_pass = 1'b1;
				owe_char(d, 1'b1);
			end
		end else if (plain_pass) begin
			owe_char(d, 1'b1);
		end else begin
			find_radix(d, found, pos);
			if (!found)
				err_seen = 1'b1;
			if (!nib_phase) begin
				diff      = pos - offset;
				held      = diff[3:0];
				nib_phase = 1'b1;
			end else begin
				diff      = pos - offset - LO_BIAS;
				whole     = {held, diff[3:0]};
				offset    = offset + OFF_STEP;
				nib_phase = 1'b0;
				if (pairs < SEED_PAIRS) begin
					seed_mem[pairs[0]] = whole;
				end else begin
					owe_char(whole ^ seed_mem[parity], 1'b1);
					parity = ~parity;
				end
				if (pairs != PAIR_MAX)
					pairs = pairs + 2'd1;
			end
		end
		if (l) begin
			flag = (m == MODE_DEC) &&
				(err_seen || (!plain_pass && (pairs < SEED_PAIRS || nib_phase)));
			if (owed_chars.size() == base)
				owe_char(8'h00, 1'b0);
			tail     = owed_chars.pop_back();
			tail.eos = 1'b1;
			tail.bad = flag;
			owed_chars.insert(owed_chars.size(), tail);
			clear_string();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			seed_lo     = 8'h00;
			seed_hi     = 8'h00;
			seed_mem[0] = 8'h00;
			seed_mem[1] = 8'h00;
			clear_string();
			owed_chars.delete();
			err_count = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			// results first, so a request taken at this edge cannot be matched
			if (out_valid && !out_stall) begin
				if (owed_chars.size() == 0) begin
					err_count++;
					$display("%0t: result not owed, expected none, got out_byte %h", $time,
						out_byte);
				end else begin
					want = owed_chars.pop_front();
					if (want.out_byte !== out_byte) begin
						err_count++;
						$display("%0t: out_byte expected %h got %h", $time, want.out_byte,
							out_byte);
					end
					if (want.has_data !== has_data) begin
						err_count++;
						$display("%0t: has_data expected %b got %b", $time, want.has_data,
							has_data);
					end
					if (want.eos !== end_of_string) begin
						err_count++;
						$display("%0t: end_of_string expected %b got %b", $time, want.eos,
							end_of_string);
					end
					if (want.bad !== bad_input) begin
						err_count++;
						$display("%0t: bad_input expected %b got %b", $time, want.bad,
							bad_input);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_request(mode, data, last);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SEED_LOW)
					seed_lo = cfg_data;
				else
					seed_hi = cfg_data;
			end
			errors  <= err_count;
			pending <= owed_chars.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for nibble_radix64_obfuscation_codec
// Encodes random passwords, feeds the stored text back for decoding (mostly
// intact, sometimes damaged), adds pass-through, noise and mixed-mode strings,
// and changes the seed bytes between phases. Both channels idle at random;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench import nrobf_pkg::*;;

	localparam int HOLD_LONG   = 300;      // one long receiver hold-off, in cycles
	localparam int IDLE_PAUSE  = 8;        // settle time once nothing is owed
	localparam int RANDOM_REQS = 85;
	localparam int RUN_LIMIT   = 10000000; // time units, many times the slowest run

	localparam logic [8*64-1:0] RADIX_SET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// every input of the block starts at a known value
	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       mode      = 1'b0;
	logic [7:0] data      = 8'h00;
	logic       last      = 1'b0;
	logic       out_stall = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_index = 1'b0;
	logic [7:0] cfg_data  = 8'h00;
	logic       in_stall, out_valid, has_data, end_of_string, bad_input, cfg_ready;
	logic [7:0] out_byte;
	int         errors, pending;

	// shared between the sender and the receiver
	bit         quiet      = 1'b0; // no idling on either side while set
	bit         hold_armed = 1'b0;
	bit         hold_done  = 1'b0;
	int         sent_reqs  = 0;
	logic [7:0] text_buf [$];      // string about to be sent
	logic [7:0] text_log [$];      // characters the receiver has taken

	always #10 clk = ~clk;

	nibble_radix64_obfuscation_codec u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.data          (data),
		.last          (last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.has_data      (has_data),
		.end_of_string (end_of_string),
		.bad_input     (bad_input),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	obf_stream_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.data          (data),
		.last          (last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.has_data      (has_data),
		.end_of_string (end_of_string),
		.bad_input     (bad_input),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	function automatic logic [7:0] any_radix();
		int idx;
		idx = $urandom_range(0, 63);
		return RADIX_SET[8*idx +: 8];
	endfunction

	// Offer one request after a random gap and hold it until it is taken.
	// Returns in the time step of the accepting edge.
	task automatic send_request(input logic m, input logic [7:0] d, input logic l);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		data     <= d;
		last     <= l;
		do @(posedge clk); while (in_stall);
		sent_reqs++;
	endtask

	// Send text_buf as one string in a single mode, last on the final element.
	task automatic send_text(input logic m);
		for (int i = 0; i < text_buf.size(); i++)
			send_request(m, text_buf[i], i == text_buf.size() - 1);
	endtask

	// Drop valid, wait until every owed result has left, then let the block
	// finish any request that gives no result of its own.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	// Write both seed bytes in one burst; only call while idle.
	task automatic set_seeds(input logic [7:0] lo, input logic [7:0] hi);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SEED_LOW;
		cfg_data  <= lo;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_SEED_HIGH;
		cfg_data  <= hi;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Encode text_buf and leave the stored text the block produced in text_buf.
	task automatic encode_and_capture();
		wait_idle();
		text_log.delete();
		send_text(MODE_ENC);
		wait_idle();
		text_buf = text_log;
	endtask

	// Receiver: stall a random number of cycles before each result, with the
	// one long hold-off taken on the first result after it is armed.
	initial begin
		int stall_for;
		wait (arst_n);
		forever begin
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				stall_for = HOLD_LONG;
			end else begin
				stall_for = quiet ? 0 : $urandom_range(0, 16);
			end
			repeat (stall_for) begin
				out_stall <= 1'b1;
				@(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (has_data)
				text_log.insert(text_log.size(), out_byte);
		end
	end

	initial begin
		#(RUN_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int       kind, len, random_from, strings_done, cut;
		logic [7:0] d;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// extreme seeds; first string is an encode so both seed entries get set
		set_seeds(8'h00, 8'hff);
		text_buf = '{8'h00, 8'hff, 8'h5a};
		send_text(MODE_ENC);
		// pass-through: first character is not the marker
		text_buf = '{8'h00, 8'hff};
		send_text(MODE_DEC);

		// swap the extremes, then round-trip a one-byte password
		wait_idle();
		set_seeds(8'hff, 8'h00);
		text_buf = '{MARKER};
		encode_and_capture();
		send_text(MODE_DEC);

		// character outside the alphabet inside a marked string
		text_buf = '{MARKER, "A", "A", "A", "*"};
		send_text(MODE_DEC);
		// too short, and a pair left half done
		text_buf = '{MARKER, "A", "B", "C"};
		send_text(MODE_DEC);
		// marker alone: a status-only result carries the end flags
		text_buf = '{MARKER};
		send_text(MODE_DEC);
		// mode change within a string, ending on a decode
		send_request(MODE_ENC, 8'h12, 1'b0);
		send_request(MODE_DEC, "Q", 1'b0);
		send_request(MODE_DEC, "x", 1'b1);

		// --- random part ---
		// arm the long hold-off ahead of a four-byte encode so the block backs up
		wait_idle();
		hold_armed   = 1'b1;
		random_from  = sent_reqs;
		strings_done = 0;
		while (sent_reqs - random_from < RANDOM_REQS) begin
			quiet = ($urandom_range(0, 3) == 0);
			kind  = (strings_done == 0) ? 0 : $urandom_range(0, 99);
			text_buf.delete();
			if (kind < 45) begin
				// round trip; sometimes damage the stored text before decoding
				len = (strings_done == 0) ? 4 : $urandom_range(1, 4);
				repeat (len) text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
				encode_and_capture();
				if ($urandom_range(0, 4) != 0) begin
					cut = $urandom_range(0, 9);
					if (cut == 0) begin
						text_buf[$urandom_range(0, text_buf.size() - 1)] =
							8'($urandom_range(0, 255));
					end else if (cut == 1) begin
						void'(text_buf.pop_back());
					end else if (cut == 2) begin
						len = $urandom_range(1, 4);
						while (text_buf.size() > len) void'(text_buf.pop_back());
					end
					send_text(MODE_DEC);
				end
			end else if (kind < 60) begin
				// pass-through text; the marker may turn up after the first character
				do d = 8'($urandom_range(0, 255)); while (d == MARKER);
				text_buf.insert(text_buf.size(), d);
				repeat ($urandom_range(0, 4))
					text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
				send_text(MODE_DEC);
			end else if (kind < 80) begin
				// marked noise: mostly alphabet characters, odd lengths allowed
				text_buf.insert(text_buf.size(), MARKER);
				repeat ($urandom_range(0, 8)) begin
					if ($urandom_range(0, 6) == 0)
						text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
					else
						text_buf.insert(text_buf.size(), any_radix());
				end
				send_text(MODE_DEC);
			end else if (kind < 92) begin
				// encode without waiting for the result
				repeat ($urandom_range(1, 5))
					text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
				send_text(MODE_ENC);
			end else begin
				// mode flips within one string
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					d = $urandom_range(0, 1) ? any_radix() : 8'($urandom_range(0, 255));
					send_request(1'($urandom_range(0, 1)), d, i == len - 1);
				end
			end
			strings_done++;
			// advance to a new seed setting every few strings
			if (strings_done % 6 == 5) begin
				wait_idle();
				set_seeds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			end
		end

		// drain and give the verdict
		quiet = 1'b0;
		wait_idle();
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/nrobf_pkg.sv
rtl/core/nrobf_step.sv
rtl/core/nibble_radix64_obfuscation_codec.sv
verif/obf_stream_checker.sv
verif/testbench.sv
